// ----- rtl/cbsd_pkg.sv -----
// shared types and constants of the cbor stream decoder
package cbsd_pkg;

    localparam int unsigned IN_W   = 8;
    localparam int unsigned ARG_W  = 64;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned OUT_TDATA_W = 88;

    localparam logic [2:0] MT_UINT   = 3'd0;
    localparam logic [2:0] MT_NEGINT = 3'd1;
    localparam logic [2:0] MT_BYTES  = 3'd2;
    localparam logic [2:0] MT_TEXT   = 3'd3;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    localparam logic [4:0] MINOR_FALSE    = 5'd20;
    localparam logic [4:0] MINOR_ARG1     = 5'd24;
    localparam logic [4:0] MINOR_RESERVED = 5'd28;

    typedef enum logic [3:0] {
        EV_UINT       = 4'd0,
        EV_NEGINT     = 4'd1,
        EV_BYTES      = 4'd2,
        EV_TEXT       = 4'd3,
        EV_ARRAY      = 4'd4,
        EV_MAP        = 4'd5,
        EV_TAG        = 4'd6,
        EV_SIMPLE     = 4'd7,
        EV_FALSE      = 4'd8,
        EV_TRUE       = 4'd9,
        EV_NULL       = 4'd10,
        EV_UNDEFINED  = 4'd11,
        EV_BYTES_DATA = 4'd12,
        EV_TEXT_DATA  = 4'd13,
        EV_ERROR      = 4'd14
    } ev_t;

    typedef enum logic [3:0] {
        ERR_INT        = 4'd0,
        ERR_BYTES      = 4'd1,
        ERR_TEXT       = 4'd2,
        ERR_ARRAY      = 4'd3,
        ERR_MAP        = 4'd4,
        ERR_TAG        = 4'd5,
        ERR_SPECIAL    = 4'd6,
        ERR_BYTES_LONG = 4'd7,
        ERR_TEXT_LONG  = 4'd8,
        ERR_COUNT_LONG = 4'd9
    } err_t;

    typedef struct packed {
        logic               valid;
        ev_t                event_res;
        logic [ARG_W-1:0]   argument;
        logic               wide;
        logic [7:0]         data_byte;
        logic               last;
        err_t               error_code;
    } result_t;

endpackage

// ----- rtl/cbor_stream_decoder.sv -----
// top level of the cbor stream decoder: input register, decode core, result register
//
//  channel | dir | tdata fields (lsb first)                              | tlast
//  s_      | in  | in_byte[7:0]                                          | -
//  m_      | out | event_res[3:0] argument[67:4] wide[68]                | last
//          |     | data_byte[76:69] error_code[80:77] zero[87:81]        |
//
// one beat in per cycle, sustained while the result side does not stall; a byte taken into the
// input register is decoded, and any result it gives is written into the result register
// synchronous active-low reset clears the parse state and both valid flags
// a stalled result holds the result register; the input register keeps taking
// a beat as long as it is empty or the result register is empty or frees in the same cycle
module cbor_stream_decoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [cbsd_pkg::IN_W-1:0]            s_tdata,   // in_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cbsd_pkg::OUT_TDATA_W-1:0]     m_tdata,   // event_res, argument, wide,
                                                            // data_byte, error_code
    output logic                                 m_tlast    // last
);
    import cbsd_pkg::*;

    logic             in_valid_reg;
    logic [IN_W-1:0]  in_byte_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          res;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    cbsd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .in_byte (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= res.valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.error_code, out_reg.data_byte, out_reg.wide,
                       out_reg.argument, out_reg.event_res};

    // a held input beat keeps its byte until the decode takes it
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register lost a held beat");

    // last only marks string payload beats
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_reg.event_res == EV_BYTES_DATA
                             || out_reg.event_res == EV_TEXT_DATA)
        else $error("last on a non-payload beat");

    // error codes appear only on error beats
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.event_res != EV_ERROR |-> out_reg.error_code == ERR_INT)
        else $error("error code on a non-error beat");

endmodule

// ----- rtl/cbsd_core.sv -----
// parse state and per-byte decode of the cbor stream decoder
module cbsd_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [7:0]              in_byte,
    output cbsd_pkg::result_t       res
);
    import cbsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEAD = 3'd0,
        PH_ARG  = 3'd1,
        PH_ARG4 = 3'd2,
        PH_ARG8 = 3'd3,
        PH_DATA = 3'd4,
        PH_ERR  = 3'd5
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [2:0]       kind_reg, kind_next;
    logic [3:0]       left_reg, left_next;
    logic [ARG_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0] pay_reg, pay_next;

    logic [2:0]       major;
    logic [4:0]       minor;
    logic [ARG_W-1:0] acc_shift;
    logic [3:0]       left_dec;
    logic [LEN_W-1:0] pay_dec;
    logic             fin;
    logic [2:0]       fin_kind;
    logic [ARG_W-1:0] fin_val;
    logic             fin_w4;
    logic             fin_w8;

    assign major     = in_byte[7:5];
    assign minor     = in_byte[4:0];
    assign acc_shift = {acc_reg[ARG_W-9:0], in_byte};
    assign left_dec  = left_reg - {3'd0, (left_reg != 4'd0)};
    assign pay_dec   = pay_reg - {{(LEN_W-1){1'b0}}, (pay_reg != '0)};

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        pay_next   = pay_reg;
        res        = '0;
        fin        = 1'b0;
        fin_kind   = major;
        fin_val    = {{(ARG_W-5){1'b0}}, minor};
        fin_w4     = 1'b0;
        fin_w8     = 1'b0;

        case (phase_reg)
            PH_HEAD: begin
                if (minor >= MINOR_RESERVED) begin
                    phase_next         = PH_ERR;
                    res.valid          = 1'b1;
                    res.event_res      = EV_ERROR;
                    res.error_code     = (major == MT_UINT) ? ERR_INT
                                                            : err_t'({1'b0, major - 3'd1});
                end else if (minor >= MINOR_ARG1) begin
                    kind_next = major;
                    left_next = 4'd1 << minor[1:0];
                    acc_next  = '0;
                    case (minor[1:0])
                        2'd3:    phase_next = PH_ARG8;
                        2'd2:    phase_next = PH_ARG4;
                        default: phase_next = PH_ARG;
                    endcase
                end else if (major == MT_SIMPLE && minor >= MINOR_FALSE) begin
                    res.valid     = 1'b1;
                    res.event_res = ev_t'({2'b10, minor[1:0]});
                end else begin
                    fin = 1'b1;
                end
            end
            PH_ARG, PH_ARG4, PH_ARG8: begin
                acc_next  = acc_shift;
                left_next = left_dec;
                if (left_dec == 4'd0) begin
                    fin      = 1'b1;
                    fin_kind = kind_reg;
                    fin_val  = acc_shift;
                    fin_w4   = (phase_reg == PH_ARG4);
                    fin_w8   = (phase_reg == PH_ARG8);
                end
            end
            PH_DATA: begin
                pay_next      = pay_dec;
                res.valid     = 1'b1;
                res.event_res = (kind_reg == MT_BYTES) ? EV_BYTES_DATA : EV_TEXT_DATA;
                res.data_byte = in_byte;
                if (pay_dec == '0) begin
                    phase_next = PH_HEAD;
                    res.last   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (fin) begin
            phase_next    = PH_HEAD;
            res.valid     = 1'b1;
            res.event_res = ev_t'({1'b0, fin_kind});
            res.argument  = fin_val;
            case (fin_kind)
                MT_UINT, MT_NEGINT: begin
                    res.wide = fin_w8 || (fin_w4 && fin_val > 64'h7FFF_FFFF);
                end
                MT_BYTES, MT_TEXT: begin
                    if (fin_w8) begin
                        phase_next     = PH_ERR;
                        res.event_res  = EV_ERROR;
                        res.argument   = '0;
                        res.error_code = (fin_kind == MT_BYTES) ? ERR_BYTES_LONG
                                                                : ERR_TEXT_LONG;
                    end else if (fin_val != '0) begin
                        pay_next   = fin_val[LEN_W-1:0];
                        phase_next = PH_DATA;
                    end
                end
                MT_ARRAY, MT_MAP: begin
                    if (fin_w8) begin
                        phase_next     = PH_ERR;
                        res.event_res  = EV_ERROR;
                        res.argument   = '0;
                        res.error_code = ERR_COUNT_LONG;
                    end
                end
                default: begin
                    res.wide = fin_w8;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEAD;
            kind_reg  <= '0;
            left_reg  <= '0;
            acc_reg   <= '0;
            pay_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            pay_reg   <= pay_next;
        end
    end

endmodule
